### hdl/crpe_pkg.sv
// shared types and constants for the catmull-rom point evaluator
`timescale 1ns / 1ps
package crpe_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W = 32;
    localparam int PT_W = 3 * COORD_W;
    localparam int ACC_W = 68;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEG, ST_U2, ST_U3, ST_BASIS, ST_FETCH, ST_LAST, ST_MAC, ST_WAIT, ST_DONE
    } t_state;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic [1:0] coord;
    } t_mac_tag;
endpackage

### hdl/crpe_ptab.sv
// control point table, one write port and one registered read port
`timescale 1ns / 1ps
module crpe_ptab #(
    parameter int DEPTH = crpe_pkg::MAX_POINTS_DEF,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [crpe_pkg::PT_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [crpe_pkg::PT_W-1:0] o_rdata
);
    import crpe_pkg::*;

    logic [PT_W-1:0] r_mem [DEPTH];
    logic [PT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/crpe_mac.sv
// multiply-accumulate with rounding and saturation of the finished sum
`timescale 1ns / 1ps
module crpe_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  crpe_pkg::t_mac_tag          i_tag,
    input  logic signed [31:0]          i_a,
    input  logic signed [32:0]          i_b,
    output logic                        o_done,
    output logic [1:0]                  o_coord,
    output logic signed [crpe_pkg::COORD_W-1:0] o_res
);
    import crpe_pkg::*;

    logic signed [64:0]      r_prod;
    t_mac_tag                r_tag;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic                    r_done;
    logic [1:0]              r_coord;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-31:0] q;

    always_comb begin
        n_acc = (r_tag.first ? '0 : r_acc) + ACC_W'(r_prod);
        rnd = r_acc + (ACC_W'(1) <<< 29);
        q = rnd[ACC_W-1:30];
        if (q > (ACC_W-30)'(32'sh7fffffff)) begin
            o_res = 32'sh7fffffff;
        end else if (q < -(ACC_W-30)'(33'sh080000000)) begin
            o_res = 32'sh80000000;
        end else begin
            o_res = q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_tag.vld) begin
            r_acc <= n_acc;
        end
        r_coord <= r_tag.coord;
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag  <= i_tag;
            r_done <= r_tag.vld && r_tag.last;
        end
    end

    assign o_done  = r_done;
    assign o_coord = r_coord;
endmodule

### hdl/catmull_rom_point_eval_core.sv
// catmull-rom point evaluator top level: table, sequencer and basis weights
//  channel | signals                                         | dir
//  input   | i_valid o_stall i_func i_point_index i_coord_*  | in
//          | i_param_t                                       |
//  output  | o_valid i_stall o_out_x o_out_y o_out_z o_segment| out
//  config  | i_cfg_we i_cfg_wdata (point_count)              | in
// a load word is written into the point table without stalling the input; an evaluate
// word stalls it until the result register is loaded, paced by the single multiplier
// doing 12 products and the four reads from the point table
// synchronous active-low reset clears the sequencer and output valid and sets point_count to 2
// input is stalled while an evaluation runs or its result still waits
`timescale 1ns / 1ps
module catmull_rom_point_eval_core #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [5:0]  i_point_index,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic [16:0] i_param_t,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic [5:0]  o_segment,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);
    import crpe_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = (AW > 7) ? AW : 7;

    t_state r_state, n_state;
    logic [6:0]  r_count;
    logic [16:0] r_t;
    logic [6:0]  r_n;
    logic [6:0]  r_seg;
    logic [16:0] r_u;
    logic [6:0]  r_idx [4];
    logic [33:0] r_u2;
    logic [50:0] r_u3;
    logic signed [31:0] r_w00, r_w01, r_t10, r_t11;
    logic [PT_W-1:0] r_p [4];
    logic [1:0]  r_coord, r_term;
    logic signed [31:0] r_res [3];
    logic        r_ovalid;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic [5:0]  r_oseg;

    logic        acc_in;
    logic        mem_we;
    logic [AW-1:0] mem_raddr;
    logic [PT_W-1:0] mem_rdata;
    logic [1:0]  rd_sel;
    logic [6:0]  n_clamp;
    logic [16:0] t_clamp;
    logic [6:0]  segs;
    logic [23:0] prod;
    logic [7:0]  seg_raw;
    logic [6:0]  seg_c;
    logic [16:0] u_c;
    logic signed [52:0] h00, h10, h11;
    logic signed [52:0] w00_f, t10_f, t11_f;
    t_mac_tag    tag;
    logic signed [31:0] mac_a;
    logic signed [32:0] mac_b;
    logic signed [32:0] c0, c1, c2, c3;
    logic        mac_done;
    logic [1:0]  mac_coord;
    logic signed [31:0] mac_res;
    logic        out_free;

    assign o_stall = (r_state != ST_IDLE);
    assign acc_in = i_valid && !o_stall;
    assign mem_we = acc_in && (i_func == FUNC_LOAD) && (32'(i_point_index) < MAX_POINTS);
    assign out_free = !r_ovalid || !i_stall;

    crpe_ptab #(.DEPTH(MAX_POINTS), .AW(AW)) u_ptab (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(IW'(i_point_index))),
        .i_wdata ({i_coord_z, i_coord_y, i_coord_x}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // segment and local parameter
    always_comb begin
        if (r_count < 7'd2) begin
            n_clamp = 7'd2;
        end else if (32'(r_count) > MAX_POINTS) begin
            n_clamp = 7'(MAX_POINTS);
        end else begin
            n_clamp = r_count;
        end
        t_clamp = (r_t > 17'd65536) ? 17'd65536 : r_t;
        segs = r_n - 7'd1;
        prod = 24'(t_clamp) * 24'(segs);
        seg_raw = prod[23:16];
        seg_c = (seg_raw > 8'(segs - 7'd1)) ? (segs - 7'd1) : seg_raw[6:0];
        u_c = 17'(prod - (24'(seg_c) << 16));
    end

    // hermite basis, exact then rounded half up to q.30
    always_comb begin
        h00 = 53'sd2 * $signed(53'(r_u3)) - 53'sd3 * $signed(53'(r_u2) << 16)
            + (53'sd1 <<< 48);
        h10 = $signed(53'(r_u3)) - 53'sd2 * $signed(53'(r_u2) << 16)
            + $signed(53'(r_u) << 32);
        h11 = $signed(53'(r_u3)) - $signed(53'(r_u2) << 16);
        w00_f = (h00 + (53'sd1 <<< 17)) >>> 18;
        t10_f = (h10 + (53'sd1 <<< 18)) >>> 19;
        t11_f = (h11 + (53'sd1 <<< 18)) >>> 19;
    end

    always_comb begin
        unique case (r_state)
            ST_U2:    rd_sel = 2'd0;
            ST_U3:    rd_sel = 2'd1;
            ST_BASIS: rd_sel = 2'd2;
            default:  rd_sel = 2'd3;
        endcase
        mem_raddr = AW'(IW'(r_idx[rd_sel]));
    end

    // operand select for the shared multiplier
    always_comb begin
        c0 = 33'($signed(r_p[0][32*r_coord +: 32]));
        c1 = 33'($signed(r_p[1][32*r_coord +: 32]));
        c2 = 33'($signed(r_p[2][32*r_coord +: 32]));
        c3 = 33'($signed(r_p[3][32*r_coord +: 32]));
        case (r_term)
            2'd0: begin mac_a = r_w00; mac_b = c1; end
            2'd1: begin mac_a = r_w01; mac_b = c2; end
            2'd2: begin mac_a = r_t10; mac_b = c2 - c0; end
            default: begin mac_a = r_t11; mac_b = c3 - c1; end
        endcase
        tag.vld   = (r_state == ST_MAC);
        tag.first = (r_term == 2'd0);
        tag.last  = (r_term == 2'd3);
        tag.coord = r_coord;
    end

    crpe_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_coord (mac_coord),
        .o_res   (mac_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (acc_in && i_func == FUNC_EVAL) n_state = ST_SEG;
            ST_SEG:   n_state = ST_U2;
            ST_U2:    n_state = ST_U3;
            ST_U3:    n_state = ST_BASIS;
            ST_BASIS: n_state = ST_FETCH;
            ST_FETCH: n_state = ST_LAST;
            ST_LAST:  n_state = ST_MAC;
            ST_MAC:   if (r_term == 2'd3 && r_coord == 2'd2) n_state = ST_WAIT;
            ST_WAIT:  if (mac_done && mac_coord == 2'd2) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= 7'd2;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_t <= i_param_t;
            r_n <= n_clamp;
        end
        case (r_state)
            ST_SEG: begin
                r_seg    <= seg_c;
                r_u      <= u_c;
                r_idx[0] <= (seg_c > 7'd0) ? seg_c - 7'd1 : 7'd0;
                r_idx[1] <= seg_c;
                r_idx[2] <= seg_c + 7'd1;
                r_idx[3] <= (seg_c + 7'd2 <= r_n - 7'd1) ? seg_c + 7'd2 : r_n - 7'd1;
            end
            ST_U2: r_u2 <= 34'(r_u) * 34'(r_u);
            ST_U3: begin
                r_u3   <= 51'(r_u2) * 51'(r_u);
                r_p[0] <= mem_rdata;
            end
            ST_BASIS: begin
                r_w00  <= 32'(w00_f);
                r_w01  <= (32'sd1 <<< 30) - 32'(w00_f);
                r_t10  <= 32'(t10_f);
                r_t11  <= 32'(t11_f);
                r_p[1] <= mem_rdata;
            end
            ST_FETCH: r_p[2] <= mem_rdata;
            ST_LAST: begin
                r_p[3]  <= mem_rdata;
                r_coord <= 2'd0;
                r_term  <= 2'd0;
            end
            ST_MAC: begin
                r_term <= r_term + 2'd1;
                if (r_term == 2'd3) begin
                    r_coord <= r_coord + 2'd1;
                end
            end
            default: ;
        endcase
        if (mac_done) begin
            r_res[mac_coord] <= mac_res;
        end
        if (r_state == ST_DONE && out_free) begin
            r_ox   <= r_res[0];
            r_oy   <= r_res[1];
            r_oz   <= r_res[2];
            r_oseg <= r_seg[5:0];
        end
    end

    assign o_valid   = r_ovalid;
    assign o_out_x   = r_ox;
    assign o_out_y   = r_oy;
    assign o_out_z   = r_oz;
    assign o_segment = r_oseg;
endmodule
